[rtl/counter_bank_with_max_tracking_macros.svh]
// ----------------------------------------------------------------------------
// counter bank assertion macros
// shared concurrent assertion forms for the counter bank rtl
// ----------------------------------------------------------------------------
`ifndef COUNTER_BANK_WITH_MAX_TRACKING_MACROS_SVH
`define COUNTER_BANK_WITH_MAX_TRACKING_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CBMT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define CBMT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/cbmt_pkg.sv]
// ----------------------------------------------------------------------------
// cbmt_pkg
// sizes, codes, types and helpers shared by the counter bank rtl
// ----------------------------------------------------------------------------
`default_nettype none

package cbmt_pkg;

    // bank geometry
    localparam int NUM_COUNTERS = 32;
    localparam int COUNT_WIDTH  = 16;
    localparam int IDX_W        = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
    localparam int CNT_W        = $clog2(NUM_COUNTERS + 1);

    // port field widths
    localparam int CFG_W     = 7;
    localparam int FUNC_W    = 3;
    localparam int INDEX_W   = 6;
    localparam int OUT_VAL_W = 16;
    localparam int MULT_W    = 7;
    localparam int ERR_W     = 2;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd32;

    // function codes
    localparam logic [FUNC_W-1:0] FUNC_INC   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_DEC   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLR   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_LIST  = 3'd4;

    // error codes
    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
    localparam logic [ERR_W-1:0] ERR_SAT   = 2'd2;

    // classified operation
    typedef enum logic [2:0] {
        K_INC,
        K_DEC,
        K_CLR,
        K_QUERY,
        K_LIST,
        K_RANGE
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [INDEX_W-1:0] idx;
    } t_op;

    // clamp the register to the number of counters that really take part
    function automatic logic [CNT_W-1:0] active_count(input logic [CFG_W-1:0] cfg);
        logic [CNT_W-1:0] n;
        if (cfg == '0) begin
            n = CNT_W'(1);
        end else if (32'(cfg) > NUM_COUNTERS) begin
            n = CNT_W'(NUM_COUNTERS);
        end else begin
            n = CNT_W'(cfg);
        end
        return n;
    endfunction

    // fit a counter value to the result field
    function automatic logic [OUT_VAL_W-1:0] to_out_val(input logic [COUNT_WIDTH-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[OUT_VAL_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/cbmt_ifs.sv]
// ----------------------------------------------------------------------------
// cbmt_ifs
// valid/ready channels for the counter bank request and result words
// ----------------------------------------------------------------------------
`default_nettype none

// request channel
interface cbmt_in_if import cbmt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [INDEX_W-1:0] index;

    modport source (output valid, output func, output index, input ready);
    modport sink   (input valid, input func, input index, output ready);
endinterface

// result channel
interface cbmt_out_if import cbmt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [INDEX_W-1:0]   index_out;
    logic [OUT_VAL_W-1:0] count_value;
    logic [OUT_VAL_W-1:0] max_value;
    logic [MULT_W-1:0]    max_multiplicity;
    logic                 last;
    logic [ERR_W-1:0]     error;

    modport source (output valid, output index_out, output count_value, output max_value,
                    output max_multiplicity, output last, output error, input ready);
    modport sink   (input valid, input index_out, input count_value, input max_value,
                    input max_multiplicity, input last, input error, output ready);
endinterface

`default_nettype wire

[rtl/cbmt_front.sv]
// ----------------------------------------------------------------------------
// cbmt_front
// accepts request words and classifies them for the execution back end
// ----------------------------------------------------------------------------
`default_nettype none

module cbmt_front import cbmt_pkg::*; (
    cbmt_in_if.sink          i_in,
    input  logic [CNT_W-1:0] i_active,
    output logic             o_push_valid,
    input  logic             i_push_ready,
    output t_op              o_push_op
);

    t_kind kind;

    // a word is taken whenever the queue has room
    assign o_push_valid = i_in.valid;
    assign i_in.ready   = i_push_ready;

    // decode the function and check the index against the counters in use
    always_comb begin
        if (i_in.func == FUNC_LIST) begin
            kind = K_LIST;
        end else if (32'(i_in.index) >= 32'(i_active)) begin
            kind = K_RANGE;
        end else begin
            case (i_in.func)
                FUNC_INC: kind = K_INC;
                FUNC_DEC: kind = K_DEC;
                FUNC_CLR: kind = K_CLR;
                default:  kind = K_QUERY;
            endcase
        end
    end

    assign o_push_op.kind = kind;
    assign o_push_op.idx  = i_in.index;

endmodule

`default_nettype wire

[rtl/cbmt_queue.sv]
// ----------------------------------------------------------------------------
// cbmt_queue
// short fifo of classified operations between front and back end
// ----------------------------------------------------------------------------
`default_nettype none

module cbmt_queue import cbmt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_op  i_push_op,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_op  o_pop_op
);

    t_op               r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              push;
    logic              pop;

    assign o_push_ready = (32'(r_cnt) < QUEUE_DEPTH);
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_op     = r_slot[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // slot storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= i_push_op;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/cbmt_back.sv]
// ----------------------------------------------------------------------------
// cbmt_back
// executes operations on the counter memory, rescans the maximum, emits words
// ----------------------------------------------------------------------------
`default_nettype none
`include "counter_bank_with_max_tracking_macros.svh"

module cbmt_back import cbmt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CNT_W-1:0] i_active,
    input  logic             i_cfg_written,
    input  logic             i_pop_valid,
    output logic             o_pop_ready,
    input  t_op              i_pop_op,
    cbmt_out_if.source       o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_SCAN,
        S_TAIL,
        S_EMIT,
        S_LIST_CHK
    } t_state;

    localparam logic [COUNT_WIDTH-1:0] FULL_SCALE = '1;

    t_state               r_state;
    logic                 r_rescan;
    logic                 r_emit_after;
    t_kind                r_kind;
    logic [INDEX_W-1:0]   r_idx;
    logic [COUNT_WIDTH-1:0] r_val;
    logic [ERR_W-1:0]     r_err;
    logic [IDX_W-1:0]     r_addr;
    logic                 r_cmp_vld;
    logic [COUNT_WIDTH-1:0] r_best;
    logic [CNT_W-1:0]     r_hits;
    logic [COUNT_WIDTH-1:0] r_max;
    logic [CNT_W-1:0]     r_mult;
    logic [CNT_W-1:0]     r_produced;

    // counter memory with a valid bit per entry, unwritten entries read as zero
    logic [COUNT_WIDTH-1:0]  r_mem [NUM_COUNTERS];
    logic [NUM_COUNTERS-1:0] r_vld;
    logic [COUNT_WIDTH-1:0]  r_rd_data;
    logic                    r_rd_vld;

    // result register
    logic                 r_ov;
    logic [INDEX_W-1:0]   r_o_idx;
    logic [OUT_VAL_W-1:0] r_o_val;
    logic [OUT_VAL_W-1:0] r_o_max;
    logic [MULT_W-1:0]    r_o_mult;
    logic                 r_o_last;
    logic [ERR_W-1:0]     r_o_err;

    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;
    logic [COUNT_WIDTH-1:0] rd_val;
    logic                   out_free;
    logic                   pop;
    logic                   last_addr;
    logic [COUNT_WIDTH-1:0] n_best;
    logic [CNT_W-1:0]       n_hits;
    logic [COUNT_WIDTH-1:0] mod_val;
    logic [ERR_W-1:0]       mod_err;
    logic                   list_match;
    logic                   list_go;
    logic                   load_out;

    assign rd_val      = r_rd_vld ? r_rd_data : '0;
    assign out_free    = !r_ov || o_out.ready;
    assign o_pop_ready = (r_state == S_IDLE) && !r_rescan;
    assign pop         = o_pop_ready && i_pop_valid;
    assign last_addr   = (CNT_W'(r_addr) == CNT_W'(i_active - 1'b1));
    assign list_match  = (rd_val == r_max);
    assign list_go     = !list_match || out_free;

    // a result word is loaded this cycle
    assign load_out = ((r_state == S_EMIT) && out_free) ||
                      ((r_state == S_LIST_CHK) && list_go && list_match);

    // running maximum and multiplicity over the scanned counters
    always_comb begin
        n_best = r_best;
        n_hits = r_hits;
        if (r_cmp_vld) begin
            if (rd_val > r_best) begin
                n_best = rd_val;
                n_hits = CNT_W'(1);
            end else if (rd_val == r_best) begin
                n_hits = r_hits + 1'b1;
            end
        end
    end

    // new value of the addressed counter
    always_comb begin
        mod_val = rd_val;
        mod_err = ERR_OK;
        case (r_kind)
            K_INC: begin
                if (rd_val == FULL_SCALE) begin
                    mod_err = ERR_SAT;
                end else begin
                    mod_val = rd_val + 1'b1;
                end
            end
            K_DEC: begin
                if (rd_val != '0) begin
                    mod_val = rd_val - 1'b1;
                end
            end
            K_CLR:   mod_val = '0;
            default: mod_val = rd_val;
        endcase
    end

    // memory port control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_addr;
        wr_en   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (pop && i_pop_op.kind != K_RANGE) begin
                    rd_en   = 1'b1;
                    rd_addr = (i_pop_op.kind == K_LIST) ? '0 : i_pop_op.idx[IDX_W-1:0];
                end
            end
            S_MOD: begin
                wr_en = (r_kind == K_INC) || (r_kind == K_DEC) || (r_kind == K_CLR);
            end
            S_SCAN: begin
                rd_en = 1'b1;
            end
            S_LIST_CHK: begin
                if (list_go && !last_addr) begin
                    rd_en   = 1'b1;
                    rd_addr = r_addr + 1'b1;
                end
            end
            default: rd_en = 1'b0;
        endcase
    end

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_addr] <= mod_val;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_vld  <= r_vld[rd_addr];
        end
    end

    // entry valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[r_addr] <= 1'b1;
        end
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rescan   <= 1'b1;
            r_ov       <= 1'b0;
            r_max      <= '0;
            r_mult     <= '0;
            r_cmp_vld  <= 1'b0;
        end else begin
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (r_rescan) begin
                        r_emit_after <= 1'b0;
                        r_addr       <= '0;
                        r_cmp_vld    <= 1'b0;
                        r_best       <= '0;
                        r_hits       <= '0;
                        r_state      <= S_SCAN;
                    end else if (pop) begin
                        r_kind <= i_pop_op.kind;
                        r_idx  <= i_pop_op.idx;
                        case (i_pop_op.kind)
                            K_RANGE: begin
                                r_val   <= '0;
                                r_err   <= ERR_RANGE;
                                r_state <= S_EMIT;
                            end
                            K_LIST: begin
                                r_addr     <= '0;
                                r_produced <= '0;
                                r_state    <= S_LIST_CHK;
                            end
                            default: begin
                                r_addr  <= i_pop_op.idx[IDX_W-1:0];
                                r_state <= S_MOD;
                            end
                        endcase
                    end
                end
                S_MOD: begin
                    r_val        <= mod_val;
                    r_err        <= mod_err;
                    r_addr       <= '0;
                    r_cmp_vld    <= 1'b0;
                    r_best       <= '0;
                    r_hits       <= '0;
                    r_emit_after <= 1'b1;
                    r_state      <= S_SCAN;
                end
                S_SCAN: begin
                    r_cmp_vld <= 1'b1;
                    r_best    <= n_best;
                    r_hits    <= n_hits;
                    if (last_addr) begin
                        r_state <= S_TAIL;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_TAIL: begin
                    r_max     <= n_best;
                    r_mult    <= n_hits;
                    r_cmp_vld <= 1'b0;
                    r_state   <= r_emit_after ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_o_idx  <= r_idx;
                        r_o_val  <= to_out_val(r_val);
                        r_o_max  <= to_out_val(r_max);
                        r_o_mult <= MULT_W'(r_mult);
                        r_o_last <= 1'b1;
                        r_o_err  <= r_err;
                        r_state  <= S_IDLE;
                    end
                end
                S_LIST_CHK: begin
                    if (list_go) begin
                        if (list_match) begin
                            r_o_idx    <= INDEX_W'(r_addr);
                            r_o_val    <= to_out_val(rd_val);
                            r_o_max    <= to_out_val(r_max);
                            r_o_mult   <= MULT_W'(r_mult);
                            r_o_last   <= (CNT_W'(r_produced + 1'b1) == r_mult);
                            r_o_err    <= ERR_OK;
                            r_produced <= r_produced + 1'b1;
                        end
                        if (last_addr) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_addr <= r_addr + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // a register write always forces a fresh scan, started from idle
            if (i_cfg_written) begin
                r_rescan <= 1'b1;
            end else if (r_state == S_IDLE) begin
                r_rescan <= 1'b0;
            end
        end
    end

    assign o_out.valid            = r_ov;
    assign o_out.index_out        = r_o_idx;
    assign o_out.count_value      = r_o_val;
    assign o_out.max_value        = r_o_max;
    assign o_out.max_multiplicity = r_o_mult;
    assign o_out.last             = r_o_last;
    assign o_out.error            = r_o_err;

    // scan and listing stay inside the counters in use
    `CBMT_ASSERT_IMP(a_scan_in_range, i_clk, i_rst_n, (r_state == S_SCAN || r_state == S_LIST_CHK), (CNT_W'(r_addr) < i_active), "scan address beyond counters in use")
    // a listing never emits more words than counters at the maximum
    `CBMT_ASSERT_IMP(a_list_bounded, i_clk, i_rst_n, (r_state == S_LIST_CHK), (r_produced <= r_mult), "listing emitted too many words")
    // a finished scan always finds at least one counter at the maximum
    `CBMT_ASSERT_NXT(a_mult_nonzero, i_clk, i_rst_n, (r_state == S_TAIL), (r_mult != '0), "empty maximum after scan")
    // no word is loaded over one still waiting to be taken
    `CBMT_ASSERT_IMP(a_no_overrun, i_clk, i_rst_n, (r_ov && !o_out.ready && r_state == S_EMIT), ##1 (r_state == S_EMIT || r_ov), "result word overwritten")

endmodule

`default_nettype wire

[rtl/counter_bank_with_max_tracking.sv]
// ----------------------------------------------------------------------------
// counter_bank_with_max_tracking
// bank of saturating counters with tracked maximum and multiplicity
// ----------------------------------------------------------------------------
// Requests enter a two-word queue and are carried out one at a time against a
// single-port counter memory. With n counters in use, an increment, decrement,
// reset or query reads, modifies and writes back the counter, rescans the maximum
// over all n counters through the memory read port, then emits the result word;
// an out-of-range index is answered with an error word and no rescan; a listing
// reads the counters in turn and may be held off by the result side. After
// reset and after every register write the maximum is rescanned (reset gives
// n = 32); requests wait in the queue meanwhile and the input stalls once full.
`default_nettype none

module counter_bank_with_max_tracking import cbmt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    cbmt_in_if.sink          i_in,
    cbmt_out_if.source       o_out,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    logic [CFG_W-1:0] r_cfg;
    logic [CNT_W-1:0] active;
    logic             push_valid;
    logic             push_ready;
    t_op              push_op;
    logic             pop_valid;
    logic             pop_ready;
    t_op              pop_op;

    // counters-in-use register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    assign active = active_count(r_cfg);

    // accept and classify
    cbmt_front u_front (
        .i_in         (i_in),
        .i_active     (active),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_op    (push_op)
    );

    // decoupling queue
    cbmt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_op    (push_op),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_op     (pop_op)
    );

    // execute and report
    cbmt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_active      (active),
        .i_cfg_written (i_cfg_we),
        .i_pop_valid   (pop_valid),
        .o_pop_ready   (pop_ready),
        .i_pop_op      (pop_op),
        .o_out         (o_out)
    );

endmodule

`default_nettype wire
